>>> sv/array_heap_bump_allocator_macros.svh
// Assertion macros shared by the array heap allocator modules.
`ifndef ARRAY_HEAP_BUMP_ALLOCATOR_MACROS_SVH
`define ARRAY_HEAP_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define AHBA_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define AHBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ahba_pkg.sv
// Package: sizes, codes and control structs of the array heap allocator.
package ahba_pkg;

	localparam int CELL_COUNT = 1024;
	localparam int SLOT_COUNT = 64;

	localparam int CELL_AW  = $clog2(CELL_COUNT);
	localparam int SLOT_AW  = $clog2(SLOT_COUNT);
	localparam int OFS_W    = CELL_AW + 1;
	localparam int CUR_W    = SLOT_AW + 1;

	localparam int ACT_W    = 2;
	localparam int LEN_W    = 16;
	localparam int HND_W    = 32;
	localparam int DATA_W   = 32;
	localparam int NEWH_W   = 6;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd2;

	// Status codes
	localparam logic STS_OK     = 1'b0;
	localparam logic STS_REJECT = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic fill;
	} ahba_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic create_ok;
		logic fill_last;
	} ahba_sts_t;

endpackage

>>> sv/ahba_req_if.sv
// Request channel interface: valid/ready with the request payload.
interface ahba_req_if;
	import ahba_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [LEN_W-1:0]         array_length;
	logic [HND_W-1:0]         array_handle;
	logic signed [DATA_W-1:0] cell_index;
	logic signed [DATA_W-1:0] write_data;

	modport source (output valid, action, array_length, array_handle, cell_index,
		write_data, input ready);
	modport sink (input valid, action, array_length, array_handle, cell_index,
		write_data, output ready);
endinterface

>>> sv/ahba_rsp_if.sv
// Response channel interface: valid/ready with the result payload.
interface ahba_rsp_if;
	import ahba_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     status;
	logic [NEWH_W-1:0]        new_handle;
	logic signed [DATA_W-1:0] read_data;

	modport source (output valid, status, new_handle, read_data, input ready);
	modport sink (input valid, status, new_handle, read_data, output ready);
endinterface

>>> sv/array_heap_bump_allocator.sv
// Read and write: the accepted request beat is captured, then executed into
// the registered response beat once the response slot is free. Create: the
// same, then a zero fill of the new array, cell by cell, on the single
// cell-memory write port; no request is taken before execute or during the fill.
// Reset clears slot valid bits, bump offset and slot cursor; cell memory and slot
// tables are undefined until written and get no clearing pass.
module array_heap_bump_allocator (
	input logic         clk,
	input logic         arst_n,
	ahba_req_if.sink    req,
	ahba_rsp_if.source  rsp
);
	import ahba_pkg::*;

	ahba_cmd_t cmd;
	ahba_sts_t sts;

	// Sequencing
	ahba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Storage and checks
	ahba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (req.action),
		.array_length (req.array_length),
		.array_handle (req.array_handle),
		.cell_index   (req.cell_index),
		.write_data   (req.write_data),
		.status       (rsp.status),
		.new_handle   (rsp.new_handle),
		.read_data    (rsp.read_data)
	);

endmodule

>>> sv/ahba_ctrl.sv
// Controller: request sequencing, zero-fill walk and response valid.
`include "array_heap_bump_allocator_macros.svh"

module ahba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ahba_pkg::ahba_cmd_t cmd,
	input  ahba_pkg::ahba_sts_t sts
);
	import ahba_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Commands and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_nx = sts.create_ok ? ST_FILL : ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Response beat valid: set on execute, dropped when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`AHBA_ASSERT_NEXT(a_accept_goes_exec, in_valid && in_ready, (state_q == ST_EXEC) && !in_ready, "accepted beat did not move to execute")
	`AHBA_ASSERT_NEXT(a_exec_posts_rsp, cmd.exec, out_valid_q, "execute did not post a response beat")

endmodule

>>> sv/ahba_dp.sv
// Datapath: request registers, slot tables, bump offset, cell memory, result.
`include "array_heap_bump_allocator_macros.svh"

module ahba_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ahba_pkg::ahba_cmd_t              cmd,
	output ahba_pkg::ahba_sts_t              sts,
	input  logic [ahba_pkg::ACT_W-1:0]       action,
	input  logic [ahba_pkg::LEN_W-1:0]       array_length,
	input  logic [ahba_pkg::HND_W-1:0]       array_handle,
	input  logic signed [ahba_pkg::DATA_W-1:0] cell_index,
	input  logic signed [ahba_pkg::DATA_W-1:0] write_data,
	output logic                             status,
	output logic [ahba_pkg::NEWH_W-1:0]      new_handle,
	output logic signed [ahba_pkg::DATA_W-1:0] read_data
);
	import ahba_pkg::*;

	localparam int SUM_W  = LEN_W + 1;
	localparam int CSUM_W = OFS_W + 1;

	// Memories
	logic [DATA_W-1:0] cell_mem  [CELL_COUNT];
	logic [OFS_W-1:0]  slot_base [SLOT_COUNT];
	logic [OFS_W-1:0]  slot_size [SLOT_COUNT];

	// Allocator state
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [OFS_W-1:0]      bump_q;
	logic [CUR_W-1:0]      cursor_q;

	// Captured request
	logic [ACT_W-1:0]   act_q;
	logic [LEN_W-1:0]   len_q;
	logic               hnd_hi_zero_q;
	logic [SLOT_AW-1:0] hnd_q;
	logic [DATA_W-1:0]  idx_q;
	logic [DATA_W-1:0]  wdata_q;
	logic [OFS_W-1:0]   sbase_rd_q;
	logic [OFS_W-1:0]   ssize_rd_q;

	// Zero-fill walk
	logic [CELL_AW-1:0] fill_base_q;
	logic [OFS_W-1:0]   fill_len_q;
	logic [OFS_W-1:0]   fill_cnt_q;
	logic [CELL_AW-1:0] fill_addr;

	// Result registers
	logic               status_q;
	logic [NEWH_W-1:0]  new_handle_q;
	logic               rd_ok_q;
	logic [DATA_W-1:0]  cell_rd_q;

	// Combinational checks
	logic               len_ok;
	logic               create_ok;
	logic [SUM_W-1:0]   fit_sum;
	logic               wrap;
	logic [CUR_W-1:0]   cur_eff;
	logic [SLOT_AW-1:0] slot_sel;
	logic [OFS_W-1:0]   base_new;
	logic               idx_in;
	logic [CSUM_W-1:0]  cell_sum;
	logic               in_mem;
	logic               acc_ok;
	logic [CELL_AW-1:0] cell_addr;
	logic               rd_en;
	logic               wr_en;

	// Create: length check, fit check, slot choice
	always_comb begin
		len_ok    = (len_q != '0) && ({1'b0, len_q} <= SUM_W'(CELL_COUNT));
		create_ok = (act_q == ACT_CREATE) && len_ok;
		fit_sum   = SUM_W'(bump_q) + {1'b0, len_q};
		wrap      = fit_sum > SUM_W'(CELL_COUNT);
		cur_eff   = wrap ? '0 : cursor_q;
		slot_sel  = (cur_eff >= CUR_W'(SLOT_COUNT)) ? '0 : cur_eff[SLOT_AW-1:0];
		base_new  = wrap ? '0 : bump_q;
	end

	// Read/write: handle and index checks, cell address
	always_comb begin
		idx_in    = !idx_q[DATA_W-1] && (idx_q[DATA_W-2:0] < (DATA_W-1)'(ssize_rd_q));
		cell_sum  = {1'b0, sbase_rd_q} + {1'b0, idx_q[OFS_W-1:0]};
		in_mem    = cell_sum < CSUM_W'(CELL_COUNT);
		acc_ok    = hnd_hi_zero_q && slot_valid_q[hnd_q] && idx_in && in_mem;
		cell_addr = cell_sum[CELL_AW-1:0];
		rd_en     = cmd.exec && (act_q == ACT_READ) && acc_ok;
		wr_en     = cmd.exec && (act_q == ACT_WRITE) && acc_ok;
	end

	assign fill_addr     = CELL_AW'(fill_base_q + fill_cnt_q[CELL_AW-1:0]);
	assign sts.create_ok = create_ok;
	assign sts.fill_last = (fill_cnt_q == OFS_W'(fill_len_q - OFS_W'(1)));

	// Request capture, slot table lookup on the incoming handle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q         <= action;
			len_q         <= array_length;
			hnd_hi_zero_q <= (array_handle[HND_W-1:SLOT_AW] == '0);
			hnd_q         <= array_handle[SLOT_AW-1:0];
			idx_q         <= cell_index;
			wdata_q       <= write_data;
			sbase_rd_q    <= slot_base[array_handle[SLOT_AW-1:0]];
			ssize_rd_q    <= slot_size[array_handle[SLOT_AW-1:0]];
		end
	end

	// Slot table writes on a good create
	always_ff @(posedge clk) begin
		if (cmd.exec && create_ok) begin
			slot_base[slot_sel] <= base_new;
			slot_size[slot_sel] <= len_q[OFS_W-1:0];
		end
	end

	// Allocator state: valid bits, bump offset, slot cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			bump_q       <= '0;
			cursor_q     <= '0;
		end else if (cmd.exec && create_ok) begin
			slot_valid_q <= (wrap ? '0 : slot_valid_q) | (SLOT_COUNT'(1) << slot_sel);
			bump_q       <= OFS_W'(base_new + len_q[OFS_W-1:0]);
			cursor_q     <= CUR_W'({1'b0, slot_sel} + CUR_W'(1));
		end
	end

	// Zero-fill counter
	always_ff @(posedge clk) begin
		if (cmd.exec && create_ok) begin
			fill_base_q <= base_new[CELL_AW-1:0];
			fill_len_q  <= len_q[OFS_W-1:0];
			fill_cnt_q  <= '0;
		end else if (cmd.fill) begin
			fill_cnt_q <= OFS_W'(fill_cnt_q + OFS_W'(1));
		end
	end

	// Cell memory write port: zero fill or write beat
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			cell_mem[fill_addr] <= '0;
		end else if (wr_en) begin
			cell_mem[cell_addr] <= wdata_q;
		end
	end

	// Cell memory registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cell_rd_q <= cell_mem[cell_addr];
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= (create_ok || acc_ok && (act_q == ACT_READ || act_q == ACT_WRITE))
				? STS_OK : STS_REJECT;
			new_handle_q <= create_ok ? NEWH_W'(slot_sel) : '0;
			rd_ok_q      <= rd_en;
		end
	end

	assign status     = status_q;
	assign new_handle = new_handle_q;
	assign read_data  = rd_ok_q ? cell_rd_q : '0;

	`AHBA_ASSERT_SAME(a_fill_in_len, cmd.fill, fill_cnt_q < fill_len_q, "zero fill ran past the array length")
	`AHBA_ASSERT_NEXT(a_create_sets_valid, cmd.exec && create_ok, slot_valid_q[new_handle_q[SLOT_AW-1:0]] && (status_q == STS_OK), "created slot not marked valid")
	`AHBA_ASSERT_SAME(a_bump_bound, cmd.exec, bump_q <= OFS_W'(CELL_COUNT), "bump offset beyond cell count")

endmodule
